>>> rtl/core/mexp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_pkg - shared definitions for the modular exponentiation block
// Default widths, register indexes, sequencer states and core status.
// ----------------------------------------------------------------------------
package mexp_pkg;

	localparam int MODULUS_BITS_DEF  = 16;
	localparam int EXPONENT_BITS_DEF = 32;

	localparam int BASE_W      = 32;
	localparam int RESULT_W    = 16;
	localparam int CFG_INDEX_W = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_EXPONENT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MODULUS  = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_EBIT,
		ST_MUL,
		ST_SQR,
		ST_FINISH
	} mexp_state_t;

	typedef struct packed {
		logic in_ready;
		logic res_valid;
	} mexp_status_t;

endpackage

>>> rtl/core/mexp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_in_if / mexp_out_if - valid/ready channels of the block
// Input channel carries the base value, output channel the result.
// ----------------------------------------------------------------------------
interface mexp_in_if
	import mexp_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BASE_W-1:0] base_value;

	modport source (output valid, output base_value, input ready);
	modport sink   (input valid, input base_value, output ready);
endinterface

interface mexp_out_if
	import mexp_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [RESULT_W-1:0] power_result;

	modport source (output valid, output power_result, input ready);
	modport sink   (input valid, input power_result, output ready);
endinterface

>>> rtl/core/mexp_modstep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_modstep - modular double-and-add step
// Returns (2*r + addend) mod n, given r < n and addend < n or addend <= 1.
// ----------------------------------------------------------------------------
module mexp_modstep #(
	parameter int MB = 16
) (
	input  logic [MB-1:0] r,
	input  logic [MB-1:0] addend,
	input  logic [MB-1:0] modulus,
	output logic [MB-1:0] r_next
);

	logic [MB:0] dbl;
	logic [MB:0] dbl_red;
	logic [MB:0] sum;
	logic [MB:0] sum_red;
	logic [MB:0] n_ext;

	assign n_ext   = {1'b0, modulus};
	assign dbl     = {r, 1'b0};
	assign dbl_red = (dbl >= n_ext) ? dbl - n_ext : dbl;
	assign sum     = dbl_red + {1'b0, addend};
	assign sum_red = (sum >= n_ext) ? sum - n_ext : sum;
	assign r_next  = sum_red[MB-1:0];

endmodule

>>> rtl/core/mexp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_core - square-and-multiply sequencer
// Reduces the base, then scans the exponent from its low bit, running every
// modular product bit-serially through one shared double-and-add step.
// ----------------------------------------------------------------------------
module mexp_core
	import mexp_pkg::*;
#(
	parameter int MB = MODULUS_BITS_DEF,
	parameter int EB = EXPONENT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [BASE_W-1:0] base,
	input  logic [EB-1:0]     exponent,
	input  logic [MB-1:0]     modulus,
	input  logic              res_take,
	output mexp_status_t      status,
	output logic [MB-1:0]     result
);

	localparam int OPW   = (MB > BASE_W) ? MB : BASE_W;
	localparam int CNT_W = $clog2(OPW + 1);
	localparam int ECW   = $clog2(EB + 1);

	mexp_state_t state_q, state_d;

	logic [MB-1:0]    r_q;
	logic [MB-1:0]    sq_q;
	logic [MB-1:0]    acc_q;
	logic [OPW-1:0]   opsh_q;
	logic [CNT_W-1:0] cnt_q;
	logic [EB-1:0]    ebits_q;
	logic [ECW-1:0]   ecnt_q;

	logic          last;
	logic          opbit;
	logic [MB-1:0] addend;
	logic [MB-1:0] r_next;
	logic [OPW-1:0] acc_al;
	logic [OPW-1:0] sq_al;

	assign last   = (cnt_q == CNT_W'(1));
	assign opbit  = opsh_q[OPW-1];
	assign acc_al = OPW'(acc_q) << (OPW - MB);
	assign sq_al  = OPW'(sq_q) << (OPW - MB);

	always_comb begin
		if (state_q == ST_REDUCE) begin
			addend = MB'(opbit);
		end else begin
			addend = opbit ? sq_q : '0;
		end
	end

	mexp_modstep #(.MB(MB)) u_step (
		.r      (r_q),
		.addend (addend),
		.modulus(modulus),
		.r_next (r_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		status.in_ready  = 1'b0;
		status.res_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				status.in_ready = 1'b1;
				if (start) begin
					state_d = (modulus == '0) ? ST_FINISH : ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				if (last) begin
					state_d = ST_EBIT;
				end
			end
			ST_EBIT: begin
				if (ecnt_q == '0) begin
					state_d = ST_FINISH;
				end else if (ebits_q[0]) begin
					state_d = ST_MUL;
				end else begin
					state_d = ST_SQR;
				end
			end
			ST_MUL: begin
				if (last) begin
					state_d = ST_SQR;
				end
			end
			ST_SQR: begin
				if (last) begin
					state_d = ST_EBIT;
				end
			end
			ST_FINISH: begin
				status.res_valid = 1'b1;
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					r_q     <= '0;
					opsh_q  <= OPW'(base) << (OPW - BASE_W);
					cnt_q   <= CNT_W'(BASE_W);
					ebits_q <= exponent;
					ecnt_q  <= ECW'(EB);
					// no reduction possible for a zero modulus
					acc_q   <= (modulus == '0) ? MB'(0) : MB'(1);
				end
			end
			ST_REDUCE: begin
				r_q    <= r_next;
				opsh_q <= opsh_q << 1;
				cnt_q  <= cnt_q - CNT_W'(1);
				if (last) begin
					sq_q <= r_next;
				end
			end
			ST_EBIT: begin
				r_q    <= '0;
				cnt_q  <= CNT_W'(MB);
				opsh_q <= ebits_q[0] ? acc_al : sq_al;
			end
			ST_MUL: begin
				r_q    <= r_next;
				opsh_q <= opsh_q << 1;
				cnt_q  <= cnt_q - CNT_W'(1);
				if (last) begin
					acc_q  <= r_next;
					r_q    <= '0;
					opsh_q <= sq_al;
					cnt_q  <= CNT_W'(MB);
				end
			end
			ST_SQR: begin
				r_q    <= r_next;
				opsh_q <= opsh_q << 1;
				cnt_q  <= cnt_q - CNT_W'(1);
				if (last) begin
					sq_q    <= r_next;
					ebits_q <= ebits_q >> 1;
					ecnt_q  <= ecnt_q - ECW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign result = acc_q;

endmodule

>>> rtl/core/modular_exponentiation_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation_top - base ^ exponent mod n, square-and-multiply
// Configuration registers, input channel, sequencer and output register.
// ----------------------------------------------------------------------------
// Each transfer on base_ch yields one power_result on result_ch. The block
// takes one item at a time: base_ch.ready is low from the transfer until the
// result is handed to the output register. Every product runs through the single
// modular double-and-add unit: the base is reduced in one step per base bit,
// then every square and every multiply costs one step per modulus bit. A zero
// modulus skips the work and yields a zero result. The output register lets a
// result wait for the sink while the next item is already being accepted.
// ----------------------------------------------------------------------------
module modular_exponentiation_top
	import mexp_pkg::*;
#(
	parameter int MODULUS_BITS  = MODULUS_BITS_DEF,
	parameter int EXPONENT_BITS = EXPONENT_BITS_DEF,
	localparam int DATA_W = (EXPONENT_BITS > MODULUS_BITS) ? EXPONENT_BITS : MODULUS_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]      cfg_data,
	mexp_in_if.sink                base_ch,
	mexp_out_if.source             result_ch
);

	logic [EXPONENT_BITS-1:0] exponent_q;
	logic [MODULUS_BITS-1:0]  modulus_q;
	logic [RESULT_W-1:0]      power_q;
	logic                     out_valid_q;

	mexp_status_t                     status;
	logic [MODULUS_BITS-1:0]          core_res;
	logic [MODULUS_BITS+RESULT_W-1:0] res_ext;
	logic                             res_take;
	logic                             start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exponent_q <= '0;
			modulus_q  <= MODULUS_BITS'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_EXPONENT: exponent_q <= cfg_data[EXPONENT_BITS-1:0];
				REG_MODULUS:  modulus_q  <= cfg_data[MODULUS_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	assign base_ch.ready = status.in_ready;
	assign start         = base_ch.valid && status.in_ready;
	assign res_take      = !out_valid_q || result_ch.ready;

	mexp_core #(
		.MB(MODULUS_BITS),
		.EB(EXPONENT_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.base    (base_ch.base_value),
		.exponent(exponent_q),
		.modulus (modulus_q),
		.res_take(res_take),
		.status  (status),
		.result  (core_res)
	);

	assign res_ext = {{RESULT_W{1'b0}}, core_res};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (status.res_valid && res_take) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (status.res_valid && res_take) begin
			power_q <= res_ext[RESULT_W-1:0];
		end
	end

	assign result_ch.valid        = out_valid_q;
	assign result_ch.power_result = power_q;

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		base_ch.valid && base_ch.ready |=> !base_ch.ready)
		else $error("input accepted again while an item is in progress");

	a_status_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(status.res_valid && status.in_ready))
		else $error("core ready for input while holding a result");

	a_result_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		status.res_valid && (modulus_q != '0) |->
			(core_res < modulus_q) || (core_res == MODULUS_BITS'(1)))
		else $error("result not reduced below the modulus");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		status.res_valid && res_take |=> result_ch.valid)
		else $error("finished result not presented on the output");

endmodule
